// ===== hdl/lfr_pkg.sv =====
// Package for the LED linear fade ramp.
// Holds the mode codes, counter widths and the divider request/response types.
// No dependencies.
package lfr_pkg;

	localparam int CNT_W     = 17;   // ramp, period and tick counters
	localparam int TICKS_W   = 16;   // fade length register
	localparam int FIELD_W   = 16;   // brightness and duty fields
	localparam int DIV_STEPS = CNT_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [TICKS_W-1:0] FADE_TICKS_RST = 16'd1000;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_FADE_IN  = 2'd1,
		MODE_FADE_OUT = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hdl/lfr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Used for the step period computation at a fade start. Depends on lfr_pkg.
module lfr_div import lfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  quo_q;
	logic [CNT_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]    shifted;
	logic [CNT_W+1:0]  diff;
	logic              fits;

	// shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[CNT_W-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		fits    = !diff[CNT_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
				cnt_q  <= STEP_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// remainder stays below den, so it fits CNT_W bits
				rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
				quo_q <= {quo_q[CNT_W-2:0], fits};
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== hdl/led_linear_fade_ramp.sv =====
// Top level of the LED linear fade ramp: sequencer, fade counters, output register.
// Uses one iterative divider for the step period. Depends on lfr_pkg, lfr_div.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------
//  in      | in_valid/in_stall  | mode[1:0], brightness[15:0]
//  out     | out_valid/out_stall| duty[15:0], fade_done
//  cfg     | cfg_we             | cfg_wdata[15:0] (fade_ticks)
//
// A tick, an unused mode, or a start whose step period needs no division is handled
// in the accepting cycle. A start that divides goes from the accepting cycle to a
// launch state for the divider, then waits for its 17 quotient bits, found one per
// cycle, and loads the period; in_stall is high in the launch and wait states.
// in_stall is also high while a result waits in the output register and out_stall
// is high. Reset clears the fade state but sets the step period to 1; fade_ticks resets to 1000.
module led_linear_fade_ramp import lfr_pkg::*; #(
	parameter int DUTY_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TICKS_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [FIELD_W-1:0] brightness,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] duty,
	output logic               fade_done
);

	localparam int CUR_W = (DUTY_BITS < CNT_W) ? DUTY_BITS : CNT_W;
	localparam int TGT_W = (DUTY_BITS < FIELD_W) ? DUTY_BITS : FIELD_W;
	localparam logic [32:0] DUTY_MAX = (33'd1 << DUTY_BITS) - 33'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT
	} state_t;

	function automatic logic [CUR_W-1:0] sat_duty(input logic [CNT_W-1:0] v);
		if (33'(v) > DUTY_MAX) begin
			return DUTY_MAX[CUR_W-1:0];
		end
		return v[CUR_W-1:0];
	endfunction

	state_t             state_q;
	logic [TICKS_W-1:0] fade_ticks_q;
	logic [CUR_W-1:0]   cur_duty_q;
	logic [CNT_W-1:0]   ramp_q;
	logic [TGT_W-1:0]   target_q;
	logic [CNT_W-1:0]   period_q;
	logic [CNT_W-1:0]   elapsed_q;
	logic [CNT_W-1:0]   phase_q;
	logic               active_q;
	logic               up_q;
	logic [CNT_W-1:0]   div_num_q;
	logic [CNT_W-1:0]   div_den_q;
	logic               out_valid_q;
	logic [FIELD_W-1:0] duty_q;
	logic               done_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic             accept;
	mode_t            in_mode;
	logic [CNT_W-1:0] level;
	logic [CNT_W-1:0] ft_ext;
	logic [CNT_W-1:0] elapsed_n;
	logic [CNT_W-1:0] phase_n;
	logic [CNT_W-1:0] ramp_n;
	logic             stepped;
	logic             last;
	logic [CNT_W-1:0] end_val;

	lfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.start = (state_q == ST_DIV_GO);
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign in_mode  = mode_t'(mode);
	assign ft_ext   = CNT_W'(fade_ticks_q);

	// level for a start: saturated brightness on fade in, present duty on fade out
	always_comb begin
		if (in_mode == MODE_FADE_IN) begin
			level = CNT_W'(sat_duty(CNT_W'(brightness)));
		end else begin
			level = CNT_W'(cur_duty_q);
		end
	end

	// one tick of an active fade
	always_comb begin
		elapsed_n = elapsed_q + CNT_W'(1);
		phase_n   = phase_q;
		ramp_n    = ramp_q;
		stepped   = 1'b0;
		if (period_q != '0) begin
			phase_n = phase_q + CNT_W'(1);
			if (phase_n >= period_q) begin
				phase_n = '0;
				stepped = 1'b1;
				if (up_q) begin
					if (ramp_q != '1) begin
						ramp_n = ramp_q + CNT_W'(1);
					end
				end else if (ramp_q != '0) begin
					ramp_n = ramp_q - CNT_W'(1);
				end
			end
		end
		last = elapsed_n >= (ft_ext + CNT_W'(1));
		// fade in keeps an overshoot, otherwise snaps up to the target
		end_val = (ramp_n < CNT_W'(target_q)) ? CNT_W'(target_q) : ramp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fade_ticks_q <= FADE_TICKS_RST;
			cur_duty_q   <= '0;
			ramp_q       <= '0;
			target_q     <= '0;
			period_q     <= CNT_W'(1);
			elapsed_q    <= '0;
			phase_q      <= '0;
			active_q     <= 1'b0;
			up_q         <= 1'b0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			out_valid_q  <= 1'b0;
			duty_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				fade_ticks_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_mode) inside
							MODE_FADE_IN, MODE_FADE_OUT: begin
								up_q      <= (in_mode == MODE_FADE_IN);
								elapsed_q <= '0;
								phase_q   <= '0;
								active_q  <= 1'b1;
								if (in_mode == MODE_FADE_IN) begin
									target_q <= level[TGT_W-1:0];
									ramp_q   <= '0;
								end else begin
									ramp_q <= level;
								end
								if (level == '0) begin
									period_q <= '0;
								end else if (level >= ft_ext) begin
									period_q <= CNT_W'(1);
								end else begin
									// ceiling of fade_ticks / level, level < fade_ticks
									div_num_q <= ft_ext + level - CNT_W'(1);
									div_den_q <= level;
									state_q   <= ST_DIV_GO;
								end
							end
							MODE_TICK: begin
								if (active_q) begin
									elapsed_q <= elapsed_n;
									phase_q   <= phase_n;
									ramp_q    <= ramp_n;
									if (last) begin
										active_q    <= 1'b0;
										out_valid_q <= 1'b1;
										done_q      <= 1'b1;
										if (up_q) begin
											cur_duty_q <= sat_duty(end_val);
											duty_q     <= FIELD_W'(sat_duty(end_val));
										end else begin
											cur_duty_q <= '0;
											duty_q     <= '0;
										end
									end else if (stepped) begin
										out_valid_q <= 1'b1;
										done_q      <= 1'b0;
										cur_duty_q  <= sat_duty(ramp_n);
										duty_q      <= FIELD_W'(sat_duty(ramp_n));
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						period_q <= div_rsp.quot;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_q;
	assign fade_done = done_q;

endmodule
